[rtl/tfla_pkg.sv]
// Shared types and constants of the tagged free-list allocator.
// No dependencies; the register block, the core, the top level and the testbench import this package.
`timescale 1ns / 1ps

package tfla_pkg;

  // Default sizes of the pool and of the version tag.
  localparam int POOL_BLOCKS_DEF = 1024;
  localparam int TAG_BITS_DEF    = 22;

  // Distance below the tag limit at which the near-limit flag rises.
  localparam int unsigned NEAR_MARGIN = 10000;

  // Configuration register widths and reset values.
  localparam int BIU_W   = 11;
  localparam int LIMIT_W = 22;
  localparam logic [BIU_W-1:0]   BIU_RESET   = BIU_W'(1024);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4194303);

  // Configuration port geometry.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes, taken from address bit 2.
  localparam logic [0:0] REG_BLOCKS = 1'b0;
  localparam logic [0:0] REG_LIMIT  = 1'b1;

  // Request codes.
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  // Configuration handed from the register block to the allocator core.
  typedef struct packed {
    logic [BIU_W-1:0]   blocks_in_use;
    logic [LIMIT_W-1:0] tag_limit;
  } cfg_t;

endpackage

[rtl/tfla_if.sv]
// Request and result channel interfaces of the tagged free-list allocator.
// No dependencies; used by the core and the top level.
`timescale 1ns / 1ps

interface tfla_req_if #(
  parameter int IDX_W = 10
);
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output req_type, output block_index, input ready);
  modport sink   (input valid, input req_type, input block_index, output ready);
endinterface

interface tfla_res_if #(
  parameter int IDX_W = 10,
  parameter int TAG_W = 22
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] granted_index;
  logic             granted;
  logic             exhausted;
  logic             reset_done;
  logic [TAG_W-1:0] tag_now;
  logic             near_limit;

  modport source (output valid, output granted_index, output granted, output exhausted,
                  output reset_done, output tag_now, output near_limit, input ready);
  modport sink   (input valid, input granted_index, input granted, input exhausted,
                  input reset_done, input tag_now, input near_limit, output ready);
endinterface

[rtl/tfla_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module tfla_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tfla_cfg.sv]
// APB-style configuration registers of the tagged free-list allocator.
// Depends on tfla_pkg.
`timescale 1ns / 1ps

module tfla_cfg
  import tfla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [BIU_W-1:0]   blocks_in_use;
  logic [LIMIT_W-1:0] tag_limit;
  logic               wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= BIU_RESET;
      tag_limit     <= LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_BLOCKS: blocks_in_use <= pwdata[BIU_W-1:0];
        REG_LIMIT:  tag_limit     <= pwdata[LIMIT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (paddr[2])
      REG_BLOCKS: prdata = APB_DATA_W'(blocks_in_use);
      REG_LIMIT:  prdata = APB_DATA_W'(tag_limit);
      default:    prdata = '0;
    endcase
  end

  assign cfg.blocks_in_use = blocks_in_use;
  assign cfg.tag_limit     = tag_limit;

endmodule

[rtl/tfla_core.sv]
// Allocator core: free-list control, link memory and result register.
// Depends on tfla_pkg, tfla_if and tfla_ram.
`timescale 1ns / 1ps

module tfla_core
  import tfla_pkg::*;
#(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  tfla_req_if.sink   req,
  tfla_res_if.source res
);

  localparam int IDX_W  = $clog2(POOL_BLOCKS);
  localparam int LINK_W = $clog2(POOL_BLOCKS + 1);
  localparam int CNT_W  = (LINK_W > BIU_W) ? LINK_W : BIU_W;
  localparam int CHK_W  = (TAG_BITS > LIMIT_W) ? TAG_BITS : LIMIT_W;
  localparam logic [LINK_W-1:0]  EMPTY_MARK = LINK_W'(POOL_BLOCKS);
  localparam logic [LIMIT_W-1:0] MARGIN     = LIMIT_W'(NEAR_MARGIN);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t              state, state_next;
  logic [LINK_W-1:0]   stack_head, head_next;
  logic [LINK_W-1:0]   fresh_index, fresh_next;
  logic [TAG_BITS-1:0] version_tag, tag_next;
  logic [TAG_BITS-1:0] tag_inc;

  logic                res_valid, res_valid_next;
  logic [IDX_W-1:0]    res_index, res_index_next;
  logic                res_granted, res_granted_next;
  logic                res_exhausted, res_exhausted_next;
  logic                res_reset_done, res_reset_done_next;
  logic [TAG_BITS-1:0] res_tag, res_tag_next;
  logic                res_near, res_near_next;
  logic                res_load;

  logic                req_acc;
  logic                head_live;
  logic                fresh_live;
  logic                free_ok;
  logic                check_hit;
  logic [LIMIT_W-1:0]  threshold;
  logic                near_calc;

  logic                ram_we;
  logic                ram_re;
  logic [LINK_W-1:0]   ram_rdata;
  logic [LINK_W-1:0]   popped_link;

  // Link memory: one entry per block, holding the next stacked block.
  tfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.block_index),
    .wdata (stack_head),
    .re    (ram_re),
    .raddr (stack_head[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // A new request enters only when idle and the result slot is empty or frees this cycle.
  assign req.ready = (state == S_IDLE) && (!res_valid || res.ready);
  assign req_acc   = req.valid && req.ready;

  // Status of the free list and of the tag.
  assign head_live  = stack_head < EMPTY_MARK;
  assign fresh_live = (CNT_W'(fresh_index) < CNT_W'(cfg.blocks_in_use)) &&
                      (fresh_index < EMPTY_MARK);
  assign free_ok    = LINK_W'(req.block_index) < EMPTY_MARK;
  assign check_hit  = CHK_W'(version_tag) >= CHK_W'(cfg.tag_limit);
  assign tag_inc    = version_tag + TAG_BITS'(1);
  assign threshold  = (cfg.tag_limit >= MARGIN) ? (cfg.tag_limit - MARGIN) : '0;
  assign popped_link = (ram_rdata > EMPTY_MARK) ? EMPTY_MARK : ram_rdata;

  // Next-state logic for the list, the tag and the result register.
  always_comb begin
    state_next          = state;
    head_next           = stack_head;
    fresh_next          = fresh_index;
    tag_next            = version_tag;
    res_valid_next      = res_valid && !res.ready;
    res_index_next      = res_index;
    res_granted_next    = res_granted;
    res_exhausted_next  = res_exhausted;
    res_reset_done_next = res_reset_done;
    res_load            = 1'b0;
    ram_we              = 1'b0;
    ram_re              = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_acc) begin
          res_load            = 1'b1;
          res_index_next      = '0;
          res_granted_next    = 1'b0;
          res_exhausted_next  = 1'b0;
          res_reset_done_next = 1'b0;
          case (req.req_type)
            REQ_ALLOC: begin
              if (head_live) begin
                // The head's link must come back from memory first.
                res_load   = 1'b0;
                ram_re     = 1'b1;
                state_next = S_POP;
              end else if (fresh_live) begin
                res_index_next   = fresh_index[IDX_W-1:0];
                res_granted_next = 1'b1;
                fresh_next       = fresh_index + LINK_W'(1);
                tag_next         = tag_inc;
              end else begin
                res_exhausted_next = 1'b1;
              end
            end
            REQ_FREE: begin
              if (free_ok) begin
                ram_we    = 1'b1;
                head_next = LINK_W'(req.block_index);
                tag_next  = tag_inc;
              end
            end
            REQ_CHECK: begin
              if (check_hit) begin
                head_next           = EMPTY_MARK;
                fresh_next          = '0;
                tag_next            = '0;
                res_reset_done_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        res_load            = 1'b1;
        res_index_next      = stack_head[IDX_W-1:0];
        res_granted_next    = 1'b1;
        res_exhausted_next  = 1'b0;
        res_reset_done_next = 1'b0;
        head_next           = popped_link;
        tag_next            = tag_inc;
        state_next          = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (res_load) begin
      res_valid_next = 1'b1;
    end
    res_tag_next  = res_load ? tag_next : res_tag;
    near_calc     = CHK_W'(tag_next) >= CHK_W'(threshold);
    res_near_next = res_load ? near_calc : res_near;
  end

  // State, list registers and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_head  <= EMPTY_MARK;
      fresh_index <= '0;
      version_tag <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      stack_head  <= head_next;
      fresh_index <= fresh_next;
      version_tag <= tag_next;
      res_valid   <= res_valid_next;
    end
    res_index      <= res_index_next;
    res_granted    <= res_granted_next;
    res_exhausted  <= res_exhausted_next;
    res_reset_done <= res_reset_done_next;
    res_tag        <= res_tag_next;
    res_near       <= res_near_next;
  end

  assign res.valid         = res_valid;
  assign res.granted_index = res_index;
  assign res.granted       = res_granted;
  assign res.exhausted     = res_exhausted;
  assign res.reset_done    = res_reset_done;
  assign res.tag_now       = res_tag;
  assign res.near_limit    = res_near;

  // The stack head is a block index or the empty marker, never beyond.
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    stack_head <= EMPTY_MARK)
    else $error("stack head beyond the empty marker");

  // The fresh counter never runs past the pool.
  a_fresh_range: assert property (@(posedge clk) disable iff (rst)
    fresh_index <= EMPTY_MARK)
    else $error("fresh index beyond the pool");

  // A pop in flight always finds the result slot free.
  a_pop_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> !res_valid)
    else $error("pop completes into an occupied result slot");

  // A pop is entered only with a live stack head, and it grants that head.
  a_pop_grant: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (res_valid && res_granted && res_index == $past(stack_head[IDX_W-1:0])))
    else $error("pop did not grant the stack head");

  // A re-formed pool reports a zero tag and no grant.
  a_reform_tag: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_reset_done) |-> (res_tag == '0 && !res_granted && !res_exhausted))
    else $error("re-formed pool with inconsistent result");

endmodule

[rtl/tagged_free_list_allocator.sv]
// Tagged free-list allocator. A stack pop goes through the pop state to the result
// register (the head's link is read from the synchronous link memory). Allocate from
// the initial chain, free, check and no-op load the result register directly. No
// request is taken during a stack pop; others every cycle while results are taken.
// Synchronous reset: empty stack, fresh index 0, tag 0, registers to their defaults;
// the link memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module tagged_free_list_allocator
  import tfla_pkg::*;
#(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  tfla_req_if.sink              req,
  tfla_res_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  // Configuration registers.
  tfla_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Free-list control and link memory.
  tfla_core #(
    .POOL_BLOCKS (POOL_BLOCKS),
    .TAG_BITS    (TAG_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .res (res)
  );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of the tagged free-list allocator: directed and random requests are
// predicted in step with the block, with random idling on both channels and register writes.
// Depends on tfla_pkg, tfla_req_if, tfla_res_if and tagged_free_list_allocator.
`timescale 1ns / 1ps

module tb_top;
  import tfla_pkg::*;

  localparam int POOL  = POOL_BLOCKS_DEF;
  localparam int IDX_W = $clog2(POOL);
  localparam int TAG_W = TAG_BITS_DEF;

  // The fourth request code does nothing but report the tag.
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam logic [APB_ADDR_W-1:0] ADDR_BLOCKS = {REG_BLOCKS, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT  = {REG_LIMIT, 2'b00};

  localparam int     PHASE_ITEMS  = 100;
  localparam int     PHASE_COUNT  = 8;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_CYCLES = 8;
  localparam longint CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [IDX_W-1:0] granted_index;
    logic             granted;
    logic             exhausted;
    logic             reset_done;
    logic [TAG_W-1:0] tag_now;
    logic             near_limit;
  } alloc_result_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tfla_req_if #(.IDX_W(IDX_W)) req_bus ();
  tfla_res_if #(.IDX_W(IDX_W), .TAG_W(TAG_W)) res_bus ();

  tagged_free_list_allocator #(
    .POOL_BLOCKS(POOL),
    .TAG_BITS   (TAG_W)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .req    (req_bus),
    .res    (res_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the pool: links of stacked blocks, stack top, next fresh block, tag.
  logic [BIU_W-1:0]   link_mem [POOL];
  logic [BIU_W-1:0]   stack_top;
  logic [BIU_W-1:0]   fresh_next;
  logic [TAG_W-1:0]   version;
  logic [BIU_W-1:0]   cfg_blocks;
  logic [LIMIT_W-1:0] cfg_limit;

  alloc_result_t pending_results [$];
  int            held_blocks [$];
  int            error_count  = 0;
  longint        cycle_count  = 0;
  bit            no_gaps      = 1'b0;
  bit            hold_request = 1'b0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Works out the result of one request and advances the shadow pool.
  function automatic alloc_result_t allocator_step(input logic [1:0] kind,
                                                   input logic [IDX_W-1:0] idx);
    alloc_result_t r;
    int            chain_len;
    int            threshold;
    r         = '{default: '0};
    chain_len = (cfg_blocks > POOL) ? POOL : int'(cfg_blocks);
    case (kind)
      REQ_ALLOC: begin
        if (stack_top < POOL) begin
          r.granted_index = stack_top[IDX_W-1:0];
          stack_top       = link_mem[stack_top];
          r.granted       = 1'b1;
          version         = version + 1'b1;
        end else if (fresh_next < chain_len) begin
          r.granted_index = fresh_next[IDX_W-1:0];
          fresh_next      = fresh_next + 1'b1;
          r.granted       = 1'b1;
          version         = version + 1'b1;
        end else begin
          r.exhausted = 1'b1;
        end
      end
      REQ_FREE: begin
        link_mem[idx] = stack_top;
        stack_top     = BIU_W'(idx);
        version       = version + 1'b1;
      end
      REQ_CHECK: begin
        if (version >= cfg_limit) begin
          stack_top    = BIU_W'(POOL);
          fresh_next   = '0;
          version      = '0;
          r.reset_done = 1'b1;
        end
      end
      default: ;
    endcase
    threshold    = (cfg_limit >= NEAR_MARGIN) ? int'(cfg_limit) - int'(NEAR_MARGIN) : 0;
    r.tag_now    = version;
    r.near_limit = (int'(version) >= threshold);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Offers one request after a random gap and records its expected result on acceptance.
  task automatic send_request(input logic [1:0] kind, input logic [IDX_W-1:0] idx);
    int            gap;
    alloc_result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= kind;
    req_bus.block_index <= idx;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    r = allocator_step(kind, idx);
    pending_results.push_back(r);

    // Keep a list of blocks handed out, so that most frees return a held block.
    if (r.granted) held_blocks.push_back(int'(r.granted_index));
    if (r.reset_done) held_blocks.delete();
    if (kind == REQ_FREE) begin
      for (int i = 0; i < held_blocks.size(); i++) begin
        if (held_blocks[i] == int'(idx)) begin
          held_blocks.delete(i);
          break;
        end
      end
    end
  endtask

  // Compares one accepted result with the oldest expectation.
  task automatic check_result();
    alloc_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with none expected: granted_index %0d, tag_now %0d",
             res_bus.granted_index, res_bus.tag_now);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("granted_index", want.granted_index, res_bus.granted_index);
    compare_field("granted", want.granted, res_bus.granted);
    compare_field("exhausted", want.exhausted, res_bus.exhausted);
    compare_field("reset_done", want.reset_done, res_bus.reset_done);
    compare_field("tag_now", want.tag_now, res_bus.tag_now);
    compare_field("near_limit", want.near_limit, res_bus.near_limit);
  endtask

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin : result_sink
    int stall;
    res_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk);
      while (!res_bus.valid) @(posedge clk);
      check_result();
    end
  end

  // Reads a register and compares it with the shadow configuration.
  task automatic reg_read(input logic [APB_ADDR_W-1:0] addr);
    logic [APB_DATA_W-1:0] want;
    want    = (addr == ADDR_BLOCKS) ? APB_DATA_W'(cfg_blocks) : APB_DATA_W'(cfg_limit);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    compare_field((addr == ADDR_BLOCKS) ? "blocks_in_use" : "tag_limit", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a register, updates the shadow copy and reads the value back.
  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_BLOCKS) cfg_blocks = data[BIU_W-1:0];
    else cfg_limit = data[LIMIT_W-1:0];
    @(posedge clk);
    reg_read(addr);
  endtask

  // Lets every outstanding request finish before the pool settings change.
  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [BIU_W-1:0] blocks, input logic [LIMIT_W-1:0] limit);
    wait_idle();
    reg_write(ADDR_BLOCKS, APB_DATA_W'(blocks));
    reg_write(ADDR_LIMIT, APB_DATA_W'(limit));
  endtask

  // One random request: mostly allocates and frees of held blocks, some noise.
  task automatic random_request();
    int               pick;
    logic [1:0]       kind;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    idx  = IDX_W'($urandom_range(0, POOL - 1));
    if (pick < 42) begin
      kind = REQ_ALLOC;
    end else if (pick < 80) begin
      kind = REQ_FREE;
      if (held_blocks.size() > 0 && $urandom_range(0, 9) < 8)
        idx = IDX_W'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
    end else if (pick < 94) begin
      kind = REQ_CHECK;
    end else begin
      kind = REQ_NOP;
    end
    send_request(kind, idx);
  endtask

  task automatic test_register_defaults();
    reg_read(ADDR_BLOCKS);
    reg_read(ADDR_LIMIT);
  endtask

  // Initial chain, freed stack, index extremes, check below the limit and the no-op code.
  task automatic test_chain_and_stack();
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_FREE, '1);
    send_request(REQ_FREE, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '1);
    send_request(REQ_CHECK, '1);
    send_request(REQ_NOP, '1);
    send_request(REQ_NOP, '0);
  endtask

  // Empty list, a chain shortened below the fresh index, an empty chain and an oversized one.
  task automatic test_exhaustion();
    set_config(BIU_W'(1), LIMIT_RESET);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_FREE, IDX_W'(5));
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    set_config('0, LIMIT_RESET);
    send_request(REQ_ALLOC, '0);
    set_config('1, LIMIT_RESET);
    send_request(REQ_ALLOC, '0);
  endtask

  // Small limits, a double free, a re-form while blocks are held and the near-limit edge.
  task automatic test_tag_limit();
    set_config('1, LIMIT_W'(5));
    send_request(REQ_FREE, IDX_W'(7));
    send_request(REQ_FREE, IDX_W'(7));
    send_request(REQ_ALLOC, '0);
    send_request(REQ_CHECK, '0);
    send_request(REQ_ALLOC, '0);
    set_config(BIU_W'(POOL), LIMIT_W'(NEAR_MARGIN + 3));
    repeat (4) send_request(REQ_ALLOC, '0);
    send_request(REQ_CHECK, '0);
    set_config(BIU_W'(POOL), '0);
    send_request(REQ_CHECK, '0);
  endtask

  // The result side holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_request = 1'b1;
    no_gaps      = 1'b1;
    repeat (40) random_request();
    no_gaps = 1'b0;
  endtask

  // Random traffic over several pool settings, the extremes among them.
  task automatic test_random_phases();
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: set_config(BIU_RESET, LIMIT_RESET);
        1: set_config(BIU_W'(1), LIMIT_W'(NEAR_MARGIN));
        2: set_config(BIU_W'(16), LIMIT_W'(40));
        3: set_config('1, LIMIT_W'(NEAR_MARGIN + 100));
        4: set_config('0, '0);
        5: set_config(BIU_W'($urandom_range(1, POOL)),
                      LIMIT_W'($urandom_range(NEAR_MARGIN, int'(LIMIT_RESET))));
        6: set_config(BIU_W'(8), LIMIT_W'($urandom_range(5, 120)));
        default: set_config(BIU_W'(POOL), LIMIT_W'(NEAR_MARGIN + $urandom_range(0, 200)));
      endcase
      no_gaps = (phase == 2 || phase == 6);
      repeat (PHASE_ITEMS) random_request();
    end
    no_gaps = 1'b0;
  endtask

  // Reset, the tests in turn, then the final verdict.
  initial begin
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= REQ_ALLOC;
    req_bus.block_index <= '0;
    stack_top  = BIU_W'(POOL);
    fresh_next = '0;
    version    = '0;
    cfg_blocks = BIU_RESET;
    cfg_limit  = LIMIT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_chain_and_stack();
    test_exhaustion();
    test_tag_limit();
    test_backpressure();
    test_random_phases();

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[tagged_free_list_allocator.f]
rtl/tfla_pkg.sv
rtl/tfla_if.sv
rtl/tfla_ram.sv
rtl/tfla_cfg.sv
rtl/tfla_core.sv
rtl/tagged_free_list_allocator.sv
tb/sv/tb_top.sv
